// ===== sv/atcc_pkg.sv =====
`default_nettype none

package atcc_pkg;

  // default sizes
  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 32;

  // cube edge register
  localparam int              CUBE_SIZE_W     = 31;
  localparam logic [30:0]     CUBE_SIZE_RESET = 31'd32768;

  // operation codes
  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_QUERY
  } state_t;

  // query token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
  } qctl_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic               last_vertex;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] box_count;
    logic       table_full;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/atcc_cell.sv =====
`default_nettype none

module atcc_cell #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 32,
  parameter int INDEX      = 0
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire  [$clog2(MAX_BOXES+1)-1:0]             stored,
  input  wire                                        wr_en,
  input  wire  [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] wr_index,
  input  wire  [3*COORD_BITS-1:0]                    wr_min,
  input  wire  [3*COORD_BITS-1:0]                    wr_max,
  input  wire  [3*((COORD_BITS > 32 ? COORD_BITS : 32)+1)-1:0] q_lo,
  input  wire  [3*((COORD_BITS > 32 ? COORD_BITS : 32)+1)-1:0] q_hi,
  input  atcc_pkg::qctl_t                            ctl_in,
  output atcc_pkg::qctl_t                            ctl_out
);
  import atcc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int WW   = (COORD_BITS > 32 ? COORD_BITS : 32) + 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);
  localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  logic [3*CB-1:0]        box_min;
  logic [3*CB-1:0]        box_max;
  logic signed [WW-1:0]   mn [3];
  logic signed [WW-1:0]   mx [3];
  logic signed [WW-1:0]   lo [3];
  logic signed [WW-1:0]   hi [3];
  logic [2:0]             axis_ok;
  logic                   used;
  qctl_t                  ctl;

  // box storage for this slot
  always_ff @(posedge clk) begin
    if (wr_en && (wr_index == IW'(INDEX))) begin
      box_min <= wr_min;
      box_max <= wr_max;
    end
  end

  // per axis: low or high corner strictly between min and max
  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign mn[a] = WW'(signed'(box_min[a*CB +: CB]));
    assign mx[a] = WW'(signed'(box_max[a*CB +: CB]));
    assign lo[a] = signed'(q_lo[a*WW +: WW]);
    assign hi[a] = signed'(q_hi[a*WW +: WW]);
    assign axis_ok[a] = ((lo[a] > mn[a]) && (lo[a] < mx[a])) ||
                        ((hi[a] > mn[a]) && (hi[a] < mx[a]));
  end

  assign used = CNTW'(INDEX) < stored;

  // pass the token on, folding in this slot's result
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= ctl_in.valid;
      ctl.hit   <= ctl_in.hit | (used & (&axis_ok));
    end
  end

  assign ctl_out = ctl;

endmodule

`default_nettype wire

// ===== sv/aabb_table_cube_collision_unit.sv =====
`default_nettype none

// Bounding box table with camera cube collision test. Vertex beats widen an
// open box and the beat flagged last_vertex commits it to a table of MAX_BOXES
// slots (a dropped box sets the sticky table_full flag); a clear beat empties
// the table. Every input beat gives exactly one output beat. A query's token
// passes a head register, then walks a row of MAX_BOXES cells, one stored box
// per cell and one cell per cycle, each testing all eight cube corners against
// its box at once. One item is worked on at a time. cube_size is to be written
// on the cfg channel only while idle; the block itself does not enforce this.
module aabb_table_cube_collision_unit #(
  parameter int MAX_BOXES  = atcc_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = atcc_pkg::COORD_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  atcc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output atcc_pkg::out_t                  out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [atcc_pkg::CUBE_SIZE_W-1:0] cfg_data
);
  import atcc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int FW   = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int WW   = FW + 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);
  localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  state_t                 state;
  state_t                 state_next;
  logic [CUBE_SIZE_W-1:0] cube_size;
  logic [CNTW-1:0]        stored;
  logic [CNTW-1:0]        stored_next;
  logic                   overflow;
  logic                   overflow_next;
  logic                   mesh_started;
  logic                   mesh_started_next;
  logic signed [CB-1:0]   open_min [3];
  logic signed [CB-1:0]   open_max [3];
  logic signed [CB-1:0]   open_min_next [3];
  logic signed [CB-1:0]   open_max_next [3];
  logic signed [CB-1:0]   coord [3];
  logic [31:0]            field [3];
  logic signed [WW-1:0]   lo_next [3];
  logic [3*WW-1:0]        q_lo;
  logic [3*WW-1:0]        q_hi;
  logic [3*CB-1:0]        wr_min;
  logic [3*CB-1:0]        wr_max;
  logic                   wr_en;
  logic                   accept;
  logic                   is_vertex;
  logic                   is_query;
  logic                   is_clear;
  qctl_t                  head;
  qctl_t                  link [MAX_BOXES+1];
  qctl_t                  tail;
  out_t                   result;

  assign accept    = in_valid & in_ready;
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  // cube edge register
  always_ff @(posedge clk) begin
    if (rst) begin
      cube_size <= CUBE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cube_size <= cfg_data;
    end
  end

  // operation decode
  always_comb begin
    is_vertex = 1'b0;
    is_query  = 1'b0;
    is_clear  = 1'b0;
    case (in_data.operation)
      OP_VERTEX: is_vertex = 1'b1;
      OP_QUERY:  is_query  = 1'b1;
      OP_CLEAR:  is_clear  = 1'b1;
      default:   ;
    endcase
  end

  // coordinates: low COORD_BITS of the field, sign carried from the top bit
  assign field[0] = in_data.coord_x;
  assign field[1] = in_data.coord_y;
  assign field[2] = in_data.coord_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [FW-1:0] raw;
    assign raw      = FW'(field[a]);
    assign coord[a] = signed'(raw[CB-1:0]);

    // open box widening
    always_comb begin
      if (!mesh_started) begin
        open_min_next[a] = coord[a];
        open_max_next[a] = coord[a];
      end else begin
        open_min_next[a] = (coord[a] < open_min[a]) ? coord[a] : open_min[a];
        open_max_next[a] = (coord[a] > open_max[a]) ? coord[a] : open_max[a];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        open_min[a] <= '0;
        open_max[a] <= '0;
      end else if (accept && is_vertex) begin
        open_min[a] <= open_min_next[a];
        open_max[a] <= open_max_next[a];
      end
    end

    assign wr_min[a*CB +: CB] = open_min_next[a];
    assign wr_max[a*CB +: CB] = open_max_next[a];

    // query corners, low corner at full width so it never wraps
    assign lo_next[a] = WW'(coord[a]) - WW'(signed'({1'b0, cube_size}));

    always_ff @(posedge clk) begin
      if (accept && is_query) begin
        q_lo[a*WW +: WW] <= lo_next[a];
        q_hi[a*WW +: WW] <= WW'(coord[a]);
      end
    end
  end

  // table bookkeeping
  assign wr_en = accept && is_vertex && in_data.last_vertex &&
                 (stored < CNTW'(MAX_BOXES));

  always_comb begin
    stored_next       = stored;
    overflow_next     = overflow;
    mesh_started_next = mesh_started;
    if (accept && is_vertex) begin
      mesh_started_next = !in_data.last_vertex;
      if (in_data.last_vertex) begin
        if (stored < CNTW'(MAX_BOXES)) begin
          stored_next = stored + CNTW'(1);
        end else begin
          overflow_next = 1'b1;
        end
      end
    end else if (accept && is_clear) begin
      stored_next   = '0;
      overflow_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored       <= '0;
      overflow     <= 1'b0;
      mesh_started <= 1'b0;
    end else begin
      stored       <= stored_next;
      overflow     <= overflow_next;
      mesh_started <= mesh_started_next;
    end
  end

  // head of the cell row
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head.valid <= accept && is_query;
      head.hit   <= 1'b0;
    end
  end

  assign link[0] = head;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    atcc_cell #(
      .MAX_BOXES (MAX_BOXES),
      .COORD_BITS(COORD_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .stored  (stored),
      .wr_en   (wr_en),
      .wr_index(stored[IW-1:0]),
      .wr_min  (wr_min),
      .wr_max  (wr_max),
      .q_lo    (q_lo),
      .q_hi    (q_hi),
      .ctl_in  (link[i]),
      .ctl_out (link[i+1])
    );
  end

  assign tail = link[MAX_BOXES];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (tail.valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !is_query) || tail.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((accept && !is_query) || tail.valid) begin
      result.hit        <= tail.valid & tail.hit;
      result.box_count  <= 7'(stored_next);
      result.table_full <= overflow_next;
    end
  end

  assign out_data = result;

  // checks
  a_tail_in_query: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == ST_QUERY))
    else $error("query token left the cell row outside a query");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stored <= CNTW'(MAX_BOXES))
    else $error("box count beyond table size");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && is_query) |=> (link[0].valid && (state == ST_QUERY)))
    else $error("accepted query did not enter the cell row");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUERY) |-> !wr_en)
    else $error("table written during a query");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
  import atcc_pkg::*;

  localparam int MAXB = MAX_BOXES_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Q16.16 constants
  localparam int ONE = 1 << 16;
  localparam int HALF = 1 << 15;
  localparam int QUARTER = 1 << 14;
  localparam int CMIN = 32'sh8000_0000;
  localparam int CMAX = 32'sh7fff_ffff;
  localparam logic [30:0] CUBE_MAX = 31'h7fff_ffff;

  typedef struct {
    in_t beat;
    bit known;
    out_t want;
  } box_step_t;

  typedef struct {
    bit known;
    out_t want;
  } reply_note_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CUBE_SIZE_W-1:0] cfg_data;

  // local copy of the box table and open mesh
  logic [30:0] cube_len;
  logic signed [31:0] tbl_min [MAXB][3];
  logic signed [31:0] tbl_max [MAXB][3];
  logic signed [31:0] open_lo [3];
  logic signed [31:0] open_hi [3];
  bit mesh_open;
  bit boxes_dropped;
  int unsigned box_total;

  box_step_t directed_steps[$];
  reply_note_t listed_replies[$];
  out_t pending_replies[$];
  int errs;
  bit send_steady;

  reply_note_t note_now;
  out_t want_now;
  out_t got_now;

  aabb_table_cube_collision_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // does any corner of the cube ending at the position sit strictly inside a box
  function automatic bit cube_hits(input longint px, input longint py, input longint pz);
    longint pos [3];
    longint lo;
    longint hi;
    longint mn;
    longint mx;
    bit all_in;
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    for (int i = 0; i < box_total && i < MAXB; i++) begin
      all_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
        hi = pos[a];
        lo = pos[a] - longint'(cube_len);
        mn = tbl_min[i][a];
        mx = tbl_max[i][a];
        if (!((lo > mn && lo < mx) || (hi > mn && hi < mx))) all_in = 1'b0;
      end
      if (all_in) return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the box table by one beat and return its reply
  function automatic out_t reply_for_beat(input in_t b);
    logic signed [31:0] c [3];
    out_t r;
    c[0] = b.coord_x;
    c[1] = b.coord_y;
    c[2] = b.coord_z;
    r = '0;
    case (b.operation)
      OP_VERTEX: begin
        for (int a = 0; a < 3; a++) begin
          if (!mesh_open) begin
            open_lo[a] = c[a];
            open_hi[a] = c[a];
          end else begin
            if (c[a] < open_lo[a]) open_lo[a] = c[a];
            if (c[a] > open_hi[a]) open_hi[a] = c[a];
          end
        end
        mesh_open = 1'b1;
        if (b.last_vertex) begin
          if (box_total < MAXB) begin
            for (int a = 0; a < 3; a++) begin
              tbl_min[box_total][a] = open_lo[a];
              tbl_max[box_total][a] = open_hi[a];
            end
            box_total++;
          end else begin
            boxes_dropped = 1'b1;
          end
          mesh_open = 1'b0;
        end
      end
      OP_QUERY: begin
        r.hit = cube_hits(c[0], c[1], c[2]);
      end
      OP_CLEAR: begin
        box_total = 0;
        boxes_dropped = 1'b0;
      end
      default: begin
      end
    endcase
    r.box_count = box_total[6:0];
    r.table_full = boxes_dropped;
    return r;
  endfunction

  function automatic in_t beat_of(input logic [1:0] op, input bit last, input int x,
                                  input int y, input int z);
    in_t b;
    b.operation = op;
    b.last_vertex = last;
    b.coord_x = x;
    b.coord_y = y;
    b.coord_z = z;
    return b;
  endfunction

  // mostly a small region so boxes and queries overlap, some extremes and noise
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return int'($urandom_range(0, 24 << 16)) - (12 << 16);
    endcase
  endfunction

  task automatic add_step(input in_t b, input bit known, input out_t want);
    box_step_t s;
    s.beat = b;
    s.known = known;
    s.want = want;
    directed_steps.insert(directed_steps.size(), s);
  endtask

  // offer one beat after a random gap and wait until it is taken
  task automatic offer(input in_t b, input bit known, input out_t want);
    reply_note_t note;
    int gap;
    note.known = known;
    note.want = want;
    if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    listed_replies.insert(listed_replies.size(), note);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_checked(input in_t b);
    offer(b, 1'b0, '0);
  endtask

  // stop offering and wait until every reply is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0 || listed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_cube(input logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random mix: whole meshes, queries, broken meshes, clears and noise
  task automatic run_random(input int count);
    int left;
    int kind;
    int verts;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        verts = $urandom_range(1, 5);
        for (int v = 0; v < verts; v++)
          offer_checked(beat_of(OP_VERTEX, v == verts - 1, pick_coord(), pick_coord(),
                                pick_coord()));
        left -= verts;
      end else if (kind < 85) begin
        offer_checked(beat_of(OP_QUERY, $urandom_range(0, 1), pick_coord(), pick_coord(),
                              pick_coord()));
        left--;
      end else if (kind < 90) begin
        verts = $urandom_range(1, 3);
        for (int v = 0; v < verts; v++)
          offer_checked(beat_of(OP_VERTEX, 1'b0, pick_coord(), pick_coord(), pick_coord()));
        left -= verts;
      end else if (kind < 94) begin
        offer_checked(beat_of(OP_CLEAR, $urandom_range(0, 1), pick_coord(), pick_coord(),
                              pick_coord()));
        left--;
      end else if (kind < 97) begin
        offer_checked(beat_of(OP_UNUSED, $urandom_range(0, 1), $urandom(), $urandom(),
                              $urandom()));
        left--;
      end else begin
        offer_checked(beat_of(2'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom(),
                              $urandom(), $urandom()));
        left--;
      end
    end
  endtask

  // track accepted beats, predict replies and compare returned beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) cube_len = cfg_data;
      if (in_valid && in_ready) begin
        note_now = listed_replies.pop_front();
        want_now = reply_for_beat(in_data);
        if (note_now.known) want_now = note_now.want;
        pending_replies.insert(pending_replies.size(), want_now);
      end
      if (out_valid && out_ready) begin
        got_now = out_data;
        if (pending_replies.size() == 0) begin
          $display("%0t: reply with none expected, got %p", $time, got_now);
          errs++;
        end else begin
          want_now = pending_replies.pop_front();
          if (got_now.hit !== want_now.hit) begin
            $display("%0t: hit expected %0b got %0b", $time, want_now.hit, got_now.hit);
            errs++;
          end
          if (got_now.box_count !== want_now.box_count) begin
            $display("%0t: box_count expected %0d got %0d", $time, want_now.box_count,
                     got_now.box_count);
            errs++;
          end
          if (got_now.table_full !== want_now.table_full) begin
            $display("%0t: table_full expected %0b got %0b", $time, want_now.table_full,
                     got_now.table_full);
            errs++;
          end
        end
      end
    end
  end

  // result side with random stalls and one long hold-off
  initial begin
    int stall;
    int taken;
    bit steady;
    taken = 0;
    steady = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 18);
      if (taken == 120) stall = 400;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // watchdog
  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    logic [30:0] cube_steps [6];
    errs = 0;
    send_steady = 1'b0;
    cube_len = CUBE_SIZE_RESET;
    box_total = 0;
    mesh_open = 1'b0;
    boxes_dropped = 1'b0;
    for (int a = 0; a < 3; a++) begin
      open_lo[a] = '0;
      open_hi[a] = '0;
    end
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table, cube edge at its reset value of one half
    add_step(beat_of(OP_QUERY, 1'b0, 0, 0, 0), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_UNUSED, 1'b1, CMAX, CMIN, CMAX), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_CLEAR, 1'b1, CMIN, CMAX, CMIN), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_VERTEX, 1'b0, -ONE, -ONE, -ONE), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_VERTEX, 1'b0, ONE, ONE, ONE), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_VERTEX, 1'b1, 0, 0, 0), 1'b1, {1'b0, 7'd1, 1'b0});
    add_step(beat_of(OP_QUERY, 1'b1, QUARTER, QUARTER, QUARTER), 1'b1, {1'b1, 7'd1, 1'b0});
    add_step(beat_of(OP_QUERY, 1'b0, ONE, ONE, ONE), 1'b0, '0);
    add_step(beat_of(OP_QUERY, 1'b0, ONE + HALF, ONE + HALF, ONE + HALF), 1'b0, '0);
    add_step(beat_of(OP_QUERY, 1'b0, -ONE, -ONE, -ONE), 1'b0, '0);
    add_step(beat_of(OP_QUERY, 1'b0, ONE + HALF, 0, 0), 1'b0, '0);
    // single vertex mesh at the coordinate extremes
    add_step(beat_of(OP_VERTEX, 1'b1, CMIN, CMAX, 0), 1'b1, {1'b0, 7'd2, 1'b0});
    // box spanning the whole range
    add_step(beat_of(OP_VERTEX, 1'b0, CMIN, CMIN, CMIN), 1'b1, {1'b0, 7'd2, 1'b0});
    add_step(beat_of(OP_VERTEX, 1'b1, CMAX, CMAX, CMAX), 1'b1, {1'b0, 7'd3, 1'b0});
    // low corner below the coordinate range must not wrap
    add_step(beat_of(OP_QUERY, 1'b0, CMIN, CMIN, CMIN), 1'b0, '0);
    add_step(beat_of(OP_QUERY, 1'b0, CMAX, CMAX, CMAX), 1'b0, '0);
    add_step(beat_of(OP_QUERY, 1'b0, CMIN + HALF, 0, 0), 1'b0, '0);
    // clear in the middle of a mesh keeps the open box
    add_step(beat_of(OP_VERTEX, 1'b0, 5 * ONE, 5 * ONE, 5 * ONE), 1'b1, {1'b0, 7'd3, 1'b0});
    add_step(beat_of(OP_CLEAR, 1'b0, 0, 0, 0), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_QUERY, 1'b0, 0, 0, 0), 1'b1, {1'b0, 7'd0, 1'b0});
    add_step(beat_of(OP_VERTEX, 1'b1, 6 * ONE, 6 * ONE, 6 * ONE), 1'b1, {1'b0, 7'd1, 1'b0});
    add_step(beat_of(OP_QUERY, 1'b0, 6 * ONE, 6 * ONE, 6 * ONE), 1'b0, '0);
    foreach (directed_steps[i])
      offer(directed_steps[i].beat, directed_steps[i].known, directed_steps[i].want);

    // fill the table past capacity, query it full, then clear the flag
    offer_checked(beat_of(OP_CLEAR, 1'b0, 0, 0, 0));
    for (int n = 0; n < MAXB + 2; n++)
      offer_checked(beat_of(OP_VERTEX, 1'b1, pick_coord(), pick_coord(), pick_coord()));
    for (int n = 0; n < 4; n++)
      offer_checked(beat_of(OP_QUERY, 1'b0, pick_coord(), pick_coord(), pick_coord()));
    offer_checked(beat_of(OP_VERTEX, 1'b0, pick_coord(), pick_coord(), pick_coord()));
    offer_checked(beat_of(OP_CLEAR, 1'b1, 0, 0, 0));
    drain();

    // random phases over several cube edges, extremes included
    cube_steps[0] = '0;
    cube_steps[1] = CUBE_MAX;
    cube_steps[2] = 31'(ONE);
    cube_steps[3] = 31'($urandom_range(1, 4 << 16));
    cube_steps[4] = 31'($urandom());
    cube_steps[5] = CUBE_SIZE_RESET;
    foreach (cube_steps[k]) begin
      write_cube(cube_steps[k]);
      run_random(150);
      drain();
    end

    repeat (MAXB + 8) @(posedge clk);
    if (errs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== aabb_table_cube_collision_unit.f =====
sv/atcc_pkg.sv
sv/atcc_cell.sv
sv/aabb_table_cube_collision_unit.sv
sim/tb_top.sv
